/* rtl/ssd_pkg.sv */
// Shared types and fixed constants of the stereo soft-clip distortion.
// Depends on nothing; imported by the divider, controller, datapath, top level and testbench.
package ssd_pkg;

  // Fixed shaper format: the driven sample is worked on in Q.24.
  localparam int SHP_FRAC = 24;
  localparam int TMAG_W   = 28;   // magnitude of the clamped sample, up to 8.0
  localparam int X2_W     = 31;   // rounded square, up to 64.0
  localparam int NUM_W    = 58;   // shaper numerator magnitude
  localparam int DEN_W    = 34;   // shaper denominator
  localparam int DVD_W    = 60;   // rounded dividend
  localparam int QUO_W    = 26;   // shaper quotient bits

  localparam logic [DEN_W-1:0] K27 = DEN_W'(27) << SHP_FRAC;

  // Register indexes of the configuration port.
  localparam logic [2:0] CFG_DRIVE    = 3'd0;
  localparam logic [2:0] CFG_TONE     = 3'd1;
  localparam logic [2:0] CFG_LEVEL    = 3'd2;
  localparam logic [2:0] CFG_MIX      = 3'd3;
  localparam logic [2:0] CFG_IN_STER  = 3'd4;
  localparam logic [2:0] CFG_OUT_STER = 3'd5;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RECIP,
    OP_RCORR,
    OP_DRIVE,
    OP_SQUARE,
    OP_NUMER,
    OP_LEVEL,
    OP_LOWPASS,
    OP_MIX_XL,
    OP_MIX_LL,
    OP_MIX_XR,
    OP_MIX_LR,
    OP_RESULT
  } ssd_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RECIP,
    ST_RCORR,
    ST_DRIVE,
    ST_SQUARE,
    ST_NUMER,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_LEVEL,
    ST_LOWPASS,
    ST_MIX_XL,
    ST_MIX_LL,
    ST_MIX_XR,
    ST_MIX_LR,
    ST_RESULT
  } ssd_state_t;

  typedef struct packed {
    ssd_op_t op;
    logic    ch;
    logic    div_start;
  } ssd_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } ssd_status_t;

endpackage

/* rtl/ssd_ifs.sv */
// Request channel interfaces of the stereo soft-clip distortion.
// Depends on nothing; used by the top level.
interface ssd_in_if #(
  parameter int SAMPLE_WIDTH = 24
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] left_in;
  logic signed [SAMPLE_WIDTH-1:0] right_in;
  logic                           block_end;

  modport source (output valid, output left_in, output right_in, output block_end,
                  input ready);
  modport sink (input valid, input left_in, input right_in, input block_end,
                output ready);
endinterface

interface ssd_out_if #(
  parameter int SAMPLE_WIDTH = 24
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] left_out;
  logic signed [SAMPLE_WIDTH-1:0] right_out;
  logic                           block_end_out;

  modport source (output valid, output left_out, output right_out, output block_end_out,
                  input ready);
  modport sink (input valid, input left_out, input right_out, input block_end_out,
                output ready);
endinterface

/* rtl/ssd_div.sv */
// Restoring divider, one quotient bit per cycle, for the shaper curve.
// Depends on ssd_pkg.
module ssd_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [ssd_pkg::DVD_W-1:0] dividend,
  input  logic [ssd_pkg::DEN_W-1:0] divisor,
  output logic                      done,
  output logic [ssd_pkg::QUO_W-1:0] quotient
);
  import ssd_pkg::*;

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0] dq_r, dq_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;

  always_comb begin
    rem_nxt  = rem_r;
    dq_nxt   = dq_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    trial    = {rem_r, dq_r[QUO_W-1]};
    if (start) begin
      // The quotient is known to fit, so the upper part is below the divisor.
      rem_nxt  = dividend[DVD_W-1 -: DEN_W];
      dq_nxt   = dividend[QUO_W-1:0];
      den_nxt  = divisor;
      cnt_nxt  = 5'(QUO_W - 1);
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DEN_W'(trial - {1'b0, den_r});
        dq_nxt  = {dq_r[QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DEN_W-1:0];
        dq_nxt  = {dq_r[QUO_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = dq_r;

endmodule

/* rtl/ssd_ctrl.sv */
// Sequencing state machine of the stereo soft-clip distortion.
// Depends on ssd_pkg; drives the datapath by command structs.
module ssd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ssd_pkg::ssd_status_t status,
  output ssd_pkg::ssd_cmd_t    cmd
);
  import ssd_pkg::*;

  ssd_state_t state_r, state_nxt;
  logic       ch_r, ch_nxt;

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    unique case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_RECIP;
      ST_RECIP:    state_nxt = ST_RCORR;
      ST_RCORR: begin
        state_nxt = ST_DRIVE;
        ch_nxt    = 1'b0;
      end
      ST_DRIVE:    state_nxt = ST_SQUARE;
      ST_SQUARE:   state_nxt = ST_NUMER;
      ST_NUMER:    state_nxt = ST_DIV_GO;
      ST_DIV_GO:   state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: if (status.div_done) state_nxt = ST_LEVEL;
      ST_LEVEL:    state_nxt = ST_LOWPASS;
      ST_LOWPASS: begin
        if (ch_r) begin
          // The mix starts on the left channel.
          state_nxt = ST_MIX_XL;
          ch_nxt    = 1'b0;
        end else begin
          state_nxt = ST_DRIVE;
          ch_nxt    = 1'b1;
        end
      end
      ST_MIX_XL:   state_nxt = ST_MIX_LL;
      ST_MIX_LL: begin
        state_nxt = ST_MIX_XR;
        ch_nxt    = 1'b1;
      end
      ST_MIX_XR:   state_nxt = ST_MIX_LR;
      ST_MIX_LR:   state_nxt = ST_RESULT;
      ST_RESULT:   if (status.out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op        = OP_NONE;
    cmd.ch        = ch_r;
    cmd.div_start = 1'b0;
    in_ready      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_LOAD;
      end
      ST_RECIP:    cmd.op = OP_RECIP;
      ST_RCORR:    cmd.op = OP_RCORR;
      ST_DRIVE:    cmd.op = OP_DRIVE;
      ST_SQUARE:   cmd.op = OP_SQUARE;
      ST_NUMER:    cmd.op = OP_NUMER;
      ST_DIV_GO:   cmd.div_start = 1'b1;
      ST_DIV_WAIT: cmd.op = OP_NONE;
      ST_LEVEL:    cmd.op = OP_LEVEL;
      ST_LOWPASS:  cmd.op = OP_LOWPASS;
      ST_MIX_XL:   cmd.op = OP_MIX_XL;
      ST_MIX_LL:   cmd.op = OP_MIX_LL;
      ST_MIX_XR:   cmd.op = OP_MIX_XR;
      ST_MIX_LR:   cmd.op = OP_MIX_LR;
      ST_RESULT:   if (status.out_free) cmd.op = OP_RESULT;
      default:     cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ch_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
    end
  end

endmodule

/* rtl/ssd_dp.sv */
// Datapath: settings, one shared multiplier, shaper divider, lowpass state,
// mixer and output register. Depends on ssd_pkg and ssd_div.
module ssd_dp #(
  parameter int SAMPLE_WIDTH  = 24,
  parameter int SETTING_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [2:0]                     cfg_index,
  input  logic [SETTING_WIDTH-1:0]       cfg_data,
  input  logic signed [SAMPLE_WIDTH-1:0] left_in,
  input  logic signed [SAMPLE_WIDTH-1:0] right_in,
  input  logic                           block_end,
  input  ssd_pkg::ssd_cmd_t              cmd,
  output ssd_pkg::ssd_status_t           status,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic signed [SAMPLE_WIDTH-1:0] left_out,
  output logic signed [SAMPLE_WIDTH-1:0] right_out,
  output logic                           block_end_out
);
  import ssd_pkg::*;

  localparam int SW    = SAMPLE_WIDTH;
  localparam int KW    = SETTING_WIDTH;
  localparam int SFRAC = SW - 1;
  localparam int KFRAC = KW - 1;
  localparam int MULW  = (SW + 3 > 32) ? SW + 3 : 32;
  localparam int PW    = 2 * MULW;
  localparam int LW    = SW + 2;
  localparam int AW    = SW + KW + 4;
  localparam int GW    = KW + 6;
  localparam int VW    = KW + 7;
  localparam int RS    = KW + 13;
  localparam int SH1   = SW + KW - 2 - SHP_FRAC;
  localparam int SH4   = SHP_FRAC + KW - SW;

  localparam logic [KW-1:0]          ONE_K  = KW'(1) << KFRAC;
  localparam logic [KW+7:0]          RECIP  = (KW+8)'((64'd1 << RS) / 100);
  localparam logic signed [PW-1:0]   U_LIM  = PW'(1) << (SW + KW + 1);
  localparam logic signed [PW-1:0]   H1     = PW'(1) << (SH1 - 1);
  localparam logic signed [PW-1:0]   H24    = PW'(1) << (SHP_FRAC - 1);
  localparam logic signed [PW-1:0]   H4     = PW'(1) << (SH4 - 1);
  localparam logic signed [PW-1:0]   HK     = PW'(1) << (KFRAC - 1);
  localparam logic signed [AW:0]     HKA    = (AW+1)'(1) << (KFRAC - 1);
  localparam logic signed [AW:0]     HKM    = (AW+1)'(1) << KFRAC;
  localparam logic signed [AW:0]     SMAX   = ((AW+1)'(1) << SFRAC) - (AW+1)'(1);
  localparam logic signed [AW:0]     SMIN   = -((AW+1)'(1) << SFRAC);
  localparam logic [KW-1:0] RST_DRIVE = (KW'(13107) > ONE_K) ? ONE_K : KW'(13107);
  localparam logic [KW-1:0] RST_TONE  = (KW'(19661) > ONE_K) ? ONE_K : KW'(19661);
  localparam logic [KW-1:0] RST_LEVEL = (KW'(26214) > ONE_K) ? ONE_K : KW'(26214);
  localparam logic [KW-1:0] RST_MIX   = (KW'(32768) > ONE_K) ? ONE_K : KW'(32768);

  // Settings.
  logic [KW-1:0] drive_r, tone_r, level_r, mix_r;
  logic          in_ster_r, out_ster_r;
  logic [KW-1:0] cfg_clamped;

  // Working registers.
  logic signed [SW-1:0]  xl_r, xr_r;
  logic                  be_r;
  logic [KW-1:0]         a_r, a_nxt;
  logic [TMAG_W-1:0]     tmag_r, tmag_nxt;
  logic                  tneg_r, tneg_nxt;
  logic [X2_W-1:0]       x2_r, x2_nxt;
  logic [NUM_W-1:0]      num_r, num_nxt;
  logic [DEN_W-1:0]      den_r, den_nxt;
  logic signed [SW:0]    s_r, s_nxt;
  logic signed [LW-1:0]  lpl_r, lpr_r, lp_nxt;
  logic signed [AW-1:0]  acc_r, acc_nxt, wl_r, wr_r, w_nxt;
  logic                  ov_r;
  logic signed [SW-1:0]  ol_r, or_r, ol_nxt, or_nxt;
  logic                  obe_r;

  // Combinational helpers.
  logic [GW-1:0]           gain;
  logic [KW:0]             dry;
  logic [VW-1:0]           tone_v, rcorr_rem;
  logic signed [SW-1:0]    xc;
  logic signed [LW-1:0]    lpc;
  logic signed [LW:0]      diff;
  logic signed [QUO_W:0]   yq, ys;
  logic signed [MULW-1:0]  ma, mb;
  logic signed [PW-1:0]    prod, uc, tsh, sq, lsh, lpsh;
  logic signed [SHP_FRAC+4:0] t29;
  logic signed [AW:0]      rl, rr, rm;
  logic signed [SW-1:0]    sl, sr, sm;
  logic [DVD_W-1:0]        dividend;
  logic [QUO_W-1:0]        quo;
  logic                    div_done;
  logic                    out_free;

  assign cfg_clamped = (cfg_data > ONE_K) ? ONE_K : cfg_data;
  assign gain   = GW'(ONE_K) + GW'(drive_r) * GW'(49);
  assign dry    = (KW+1)'(ONE_K) - (KW+1)'(mix_r);
  assign tone_v = VW'(ONE_K) * VW'(2) + VW'(tone_r) * VW'(98) + VW'(50);
  assign rcorr_rem = tone_v - VW'(a_r) * VW'(100);
  assign xc     = cmd.ch ? xr_r : xl_r;
  assign lpc    = cmd.ch ? lpr_r : lpl_r;
  assign diff   = (LW+1)'(s_r) - (LW+1)'(lpc);
  assign yq     = {1'b0, quo};
  assign ys     = tneg_r ? -yq : yq;
  assign dividend = DVD_W'(num_r) + DVD_W'(den_r >> 1);
  assign out_free = !ov_r || out_ready;

  assign status.div_done = div_done;
  assign status.out_free = out_free;

  ssd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (den_r),
    .done     (div_done),
    .quotient (quo)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.op)
      OP_RECIP: begin
        ma = MULW'(tone_v);
        mb = MULW'(RECIP);
      end
      OP_DRIVE: begin
        ma = MULW'(xc);
        mb = MULW'(gain);
      end
      OP_SQUARE: begin
        ma = MULW'(tmag_r);
        mb = MULW'(tmag_r);
      end
      OP_NUMER: begin
        ma = MULW'(tmag_r);
        mb = MULW'(K27 + DEN_W'(x2_r));
      end
      OP_LEVEL: begin
        ma = MULW'(ys);
        mb = MULW'(level_r);
      end
      OP_LOWPASS: begin
        ma = MULW'(diff);
        mb = MULW'(a_r);
      end
      OP_MIX_XL, OP_MIX_XR: begin
        ma = MULW'(xc);
        mb = MULW'(dry);
      end
      OP_MIX_LL, OP_MIX_LR: begin
        ma = MULW'(lpc);
        mb = MULW'(mix_r);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod = ma * mb;

  // Post-processing of the product for each step.
  always_comb begin
    a_nxt    = a_r;
    if (cmd.op == OP_RECIP) begin
      a_nxt = prod[RS+KW-1:RS];
    end else if (cmd.op == OP_RCORR && rcorr_rem >= VW'(100)) begin
      a_nxt = a_r + KW'(1);
    end

    // Drive: clamp to eight, round to Q.24.
    uc = prod;
    if (prod > U_LIM) begin
      uc = U_LIM;
    end else if (prod < -U_LIM) begin
      uc = -U_LIM;
    end
    tsh      = (uc + H1) >>> SH1;
    t29      = tsh[SHP_FRAC+4:0];
    tneg_nxt = t29[SHP_FRAC+4];
    tmag_nxt = t29[SHP_FRAC+4] ? TMAG_W'(-t29) : TMAG_W'(t29);

    sq      = prod + H24;
    x2_nxt  = sq[SHP_FRAC+X2_W-1:SHP_FRAC];
    num_nxt = prod[NUM_W-1:0];
    den_nxt = K27 + DEN_W'(x2_r) * DEN_W'(9);

    lsh   = (prod + H4) >>> SH4;
    s_nxt = lsh[SW:0];

    lpsh   = (prod + HK) >>> KFRAC;
    lp_nxt = lpc + lpsh[LW-1:0];

    acc_nxt = prod[AW-1:0];
    w_nxt   = acc_r + prod[AW-1:0];
  end

  // Rounding and saturation of the mixed result.
  always_comb begin
    rl = ((AW+1)'(wl_r) + HKA) >>> KFRAC;
    rr = ((AW+1)'(wr_r) + HKA) >>> KFRAC;
    rm = ((AW+1)'(wl_r) + (AW+1)'(wr_r) + HKM) >>> (KFRAC + 1);
    sl = (rl > SMAX) ? SW'(SMAX) : ((rl < SMIN) ? SW'(SMIN) : SW'(rl));
    sr = (rr > SMAX) ? SW'(SMAX) : ((rr < SMIN) ? SW'(SMIN) : SW'(rr));
    sm = (rm > SMAX) ? SW'(SMAX) : ((rm < SMIN) ? SW'(SMIN) : SW'(rm));
    ol_nxt = out_ster_r ? sl : sm;
    or_nxt = out_ster_r ? sr : sm;
  end

  // Settings registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_r    <= RST_DRIVE;
      tone_r     <= RST_TONE;
      level_r    <= RST_LEVEL;
      mix_r      <= RST_MIX;
      in_ster_r  <= 1'b1;
      out_ster_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DRIVE:    drive_r    <= cfg_clamped;
        CFG_TONE:     tone_r     <= cfg_clamped;
        CFG_LEVEL:    level_r    <= cfg_clamped;
        CFG_MIX:      mix_r      <= cfg_clamped;
        CFG_IN_STER:  in_ster_r  <= cfg_data[0];
        CFG_OUT_STER: out_ster_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      xl_r <= left_in;
      xr_r <= in_ster_r ? right_in : left_in;
      be_r <= block_end;
    end
    a_r <= a_nxt;
    if (cmd.op == OP_DRIVE) begin
      tmag_r <= tmag_nxt;
      tneg_r <= tneg_nxt;
    end
    if (cmd.op == OP_SQUARE) x2_r <= x2_nxt;
    if (cmd.op == OP_NUMER) begin
      num_r <= num_nxt;
      den_r <= den_nxt;
    end
    if (cmd.op == OP_LEVEL) s_r <= s_nxt;
    if (cmd.op == OP_MIX_XL || cmd.op == OP_MIX_XR) acc_r <= acc_nxt;
    if (cmd.op == OP_MIX_LL) wl_r <= w_nxt;
    if (cmd.op == OP_MIX_LR) wr_r <= w_nxt;
    if (cmd.op == OP_RESULT) begin
      ol_r  <= ol_nxt;
      or_r  <= or_nxt;
      obe_r <= be_r;
    end
  end

  // Lowpass state and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lpl_r <= '0;
      lpr_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      if (cmd.op == OP_LOWPASS) begin
        if (cmd.ch) begin
          lpr_r <= lp_nxt;
        end else begin
          lpl_r <= lp_nxt;
        end
      end
      if (cmd.op == OP_RESULT) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_valid     = ov_r;
  assign left_out      = ol_r;
  assign right_out     = or_r;
  assign block_end_out = obe_r;

endmodule

/* rtl/stereo_softclip_distortion.sv */
// Top level of the stereo soft-clip distortion: controller plus datapath.
// Depends on ssd_pkg, ssd_ifs, ssd_ctrl and ssd_dp.
//
// The block takes one stereo frame per request and returns one processed
// frame per request, in order. Each channel is driven by a gain of one to
// fifty, clamped to plus or minus eight, passed through the rational curve
// x(27+x^2)/(27+9x^2), scaled by the output level, smoothed by a one-pole
// lowpass whose coefficient follows the tone setting, and mixed with the dry
// input. The input is ready again in the same cycle in which a frame's
// result becomes valid. The bit-serial divider of the shaper runs once on
// each channel for 26 quotient bits, and the controller waits until its
// completion is seen; the other steps are single steps around the one
// shared multiplier, and the acceptance step. A new frame is accepted once
// the previous one has reached the output register, so a result may wait
// there while the next frame is already at work; a second result then
// holds the controller until the first has been taken. The user must
// write settings through the plain write port only while the block is
// idle; the block does not enforce this. Values above one are taken as one.
module stereo_softclip_distortion #(
  parameter int SAMPLE_WIDTH  = 24,
  parameter int SETTING_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_index,
  input  logic [SETTING_WIDTH-1:0] cfg_data,
  ssd_in_if.sink                   in_chan,
  ssd_out_if.source                out_chan
);
  import ssd_pkg::*;

  ssd_cmd_t    cmd;
  ssd_status_t status;

  // The controller walks the steps of one frame and owns the input handshake.
  ssd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds settings, lowpass state and the output register.
  ssd_dp #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .SETTING_WIDTH (SETTING_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .left_in       (in_chan.left_in),
    .right_in      (in_chan.right_in),
    .block_end     (in_chan.block_end),
    .cmd           (cmd),
    .status        (status),
    .out_ready     (out_chan.ready),
    .out_valid     (out_chan.valid),
    .left_out      (out_chan.left_out),
    .right_out     (out_chan.right_out),
    .block_end_out (out_chan.block_end_out)
  );

endmodule

/* tb/stereo_softclip_distortion_tb.sv */
// Testbench of the stereo soft-clip distortion: drives frames, predicts each
// processed frame in fixed point and checks every result. Depends on ssd_pkg
// and ssd_ifs in rtl and on the top level stereo_softclip_distortion.
`timescale 1ns / 100ps

module stereo_softclip_distortion_tb;
  import ssd_pkg::*;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;

  ssd_in_if #(.SAMPLE_WIDTH(24)) in_chan ();
  ssd_out_if #(.SAMPLE_WIDTH(24)) out_chan ();

  stereo_softclip_distortion #(.SAMPLE_WIDTH(24), .SETTING_WIDTH(16)) DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_chan(in_chan.sink), .out_chan(out_chan.source)
  );

  typedef struct packed {
    logic signed [23:0] left;
    logic signed [23:0] right;
    logic               last;
  } frame_t;

  // Settings as the block sees them, already clamped to one.
  longint drive_k, tone_k, level_k, mix_k;
  bit     stereo_in, stereo_out;
  longint smooth_l, smooth_r;

  frame_t expected_frames[$];
  int     error_count;
  bit     quiet_in;          // sender never idles while set
  bit     quiet_out;         // receiver never idles while set
  int     hold_cycles;       // receiver holds off this many cycles when set

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Round half up, then shift; >>> on longint is arithmetic.
  function automatic longint rnd_shift(longint v, int s);
    if (s == 0) return v;
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint sat24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint clamp_one(logic [15:0] v);
    return (v > 16'd32768) ? 32768 : longint'(v);
  endfunction

  // Drive, clamp, soft-clip and level scaling of one sample.
  function automatic longint shaped(longint x, longint gain);
    longint u, lim, t, x2, num, den, mag, y;
    u   = x * gain;
    lim = longint'(8) << 38;
    if (u > lim) u = lim;
    if (u < -lim) u = -lim;
    t   = rnd_shift(u, 14);
    x2  = rnd_shift(t * t, 24);
    num = t * ((longint'(27) << 24) + x2);
    den = (longint'(27) << 24) + 9 * x2;
    mag = (num < 0) ? -num : num;
    y   = (mag + den / 2) / den;
    if (num < 0) y = -y;
    return rnd_shift(y * level_k, 16);
  endfunction

  // Advances the lowpass state by one frame and returns the processed frame.
  function automatic frame_t distort(frame_t f);
    longint xl, xr, gain, a, dry, wl, wr, yl, yr;
    frame_t r;
    xl   = f.left;
    xr   = stereo_in ? longint'(f.right) : xl;
    gain = 32768 + 49 * drive_k;
    a    = (2 * 32768 + 98 * tone_k + 50) / 100;
    dry  = 32768 - mix_k;
    smooth_l = smooth_l + rnd_shift(a * (shaped(xl, gain) - smooth_l), 15);
    smooth_r = smooth_r + rnd_shift(a * (shaped(xr, gain) - smooth_r), 15);
    wl = xl * dry + smooth_l * mix_k;
    wr = xr * dry + smooth_r * mix_k;
    if (stereo_out) begin
      yl = sat24(rnd_shift(wl, 15));
      yr = sat24(rnd_shift(wr, 15));
    end else begin
      yl = sat24(rnd_shift(wl + wr, 16));
      yr = yl;
    end
    r.left  = yl[23:0];
    r.right = yr[23:0];
    r.last  = f.last;
    return r;
  endfunction

  // Sends one request and records its prediction once it is accepted.
  // Valid stays high into the next request unless the sender idles; drain lowers it.
  task automatic send_frame(frame_t f);
    while (!quiet_in && $urandom_range(99) < 37) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.left_in   <= f.left;
    in_chan.right_in  <= f.right;
    in_chan.block_end <= f.last;
    do @(posedge clk); while (!in_chan.ready);
    expected_frames.push_back(distort(f));
    @(negedge clk);
  endtask

  // Waits until every result has come, then lets the block settle.
  task automatic drain;
    in_chan.valid <= 1'b0;
    while (expected_frames.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_DRIVE:    drive_k    = clamp_one(val);
      CFG_TONE:     tone_k     = clamp_one(val);
      CFG_LEVEL:    level_k    = clamp_one(val);
      CFG_MIX:      mix_k      = clamp_one(val);
      CFG_IN_STER:  stereo_in  = val[0];
      CFG_OUT_STER: stereo_out = val[0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic [15:0] d, logic [15:0] t, logic [15:0] l,
                         logic [15:0] m, bit si, bit so);
    write_reg(CFG_DRIVE, d);
    write_reg(CFG_TONE, t);
    write_reg(CFG_LEVEL, l);
    write_reg(CFG_MIX, m);
    write_reg(CFG_IN_STER, {15'd0, si});
    write_reg(CFG_OUT_STER, {15'd0, so});
  endtask

  function automatic logic [15:0] any_setting();
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'd32768;
      2: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly musical levels, with full-scale extremes and raw bit patterns.
  function automatic logic [23:0] any_sample();
    case ($urandom_range(7))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($urandom_range(2000)) - 24'd1000;
      3, 4: return 24'($urandom);
      default: return 24'(int'($urandom_range(400000)) - 200000);
    endcase
  endfunction

  function automatic frame_t any_frame();
    frame_t f;
    f.left  = any_sample();
    f.right = any_sample();
    f.last  = 1'($urandom_range(1));
    return f;
  endfunction

  // Full-scale samples, zeros and one-LSB steps, with every input and output
  // mode and both ends of each setting covered across the phases.
  task automatic test_directed;
    frame_t f;
    set_all(16'd32768, 16'd32768, 16'd32768, 16'd32768, 1'b1, 1'b1);
    send_frame('{24'h7FFFFF, 24'h800000, 1'b1});
    send_frame('{24'h800000, 24'h7FFFFF, 1'b0});
    send_frame('{24'h000000, 24'h000001, 1'b1});
    send_frame('{24'hFFFFFF, 24'h000000, 1'b0});
    drain();
    set_all(16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0);
    send_frame('{24'h7FFFFF, 24'h123456, 1'b0});
    send_frame('{24'h800000, 24'h7FFFFF, 1'b1});
    send_frame('{24'h400000, 24'h800000, 1'b0});
    drain();
    // Settings above one behave as one; unknown indexes are ignored.
    set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    write_reg(3'd6, 16'h1234);
    write_reg(3'd7, 16'hFFFF);
    send_frame('{24'h7FFFFF, 24'h7FFFFF, 1'b1});
    send_frame('{24'h800000, 24'h800000, 1'b0});
    send_frame('{24'h200000, 24'hE00000, 1'b1});
    drain();
    set_all(16'd13107, 16'd19661, 16'd26214, 16'd16384, 1'b0, 1'b1);
    for (int i = 0; i < 6; i++) begin
      f = any_frame();
      send_frame(f);
    end
    drain();
  endtask

  // Random frames over a sequence of random settings.
  task automatic test_random(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      set_all(any_setting(), any_setting(), any_setting(), any_setting(),
              1'($urandom_range(1)), 1'($urandom_range(1)));
      quiet_in  = (p == 2);
      quiet_out = (p == 2);
      for (int i = 0; i < per_phase; i++) send_frame(any_frame());
      drain();
    end
    quiet_in  = 1'b0;
    quiet_out = 1'b0;
  endtask

  // The receiver holds off while frames keep being offered, so the block
  // fills and stalls its input.
  task automatic test_backpressure;
    hold_cycles = 600;
    quiet_in = 1'b1;
    for (int i = 0; i < 20; i++) send_frame(any_frame());
    quiet_in = 1'b0;
    drain();
  endtask

  // Receiver side: random stalls, or a long counted hold-off when asked.
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_chan.ready <= 1'b0;
        hold_cycles = hold_cycles - 1;
      end else begin
        out_chan.ready <= quiet_out || ($urandom_range(99) >= 37);
      end
    end
  end

  // Compares each accepted result with the oldest prediction.
  initial begin
    frame_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready) begin
        if (expected_frames.size() == 0) begin
          $error("result with no request outstanding");
          error_count++;
        end else begin
          want = expected_frames.pop_front();
          if (out_chan.left_out !== want.left) begin
            $error("left_out expected %0d got %0d", want.left, out_chan.left_out);
            error_count++;
          end
          if (out_chan.right_out !== want.right) begin
            $error("right_out expected %0d got %0d", want.right, out_chan.right_out);
            error_count++;
          end
          if (out_chan.block_end_out !== want.last) begin
            $error("block_end_out expected %0b got %0b", want.last,
                   out_chan.block_end_out);
            error_count++;
          end
        end
      end
    end
  end

  // Worst case is roughly 1400 frames.
  initial begin
    #20ms;
    $display("stereo_softclip_distortion_tb: errors");
    $finish;
  end

  initial begin
    error_count = 0;
    quiet_in = 1'b0;
    quiet_out = 1'b0;
    hold_cycles = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_chan.valid = 1'b0;
    in_chan.left_in = '0;
    in_chan.right_in = '0;
    in_chan.block_end = 1'b0;
    drive_k = 13107;
    tone_k = 19661;
    level_k = 26214;
    mix_k = 32768;
    stereo_in = 1'b1;
    stereo_out = 1'b1;
    smooth_l = 0;
    smooth_r = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // Reset values first, with the sender pausing until all has come back.
    for (int i = 0; i < 4; i++) send_frame(any_frame());
    drain();
    test_directed();
    test_backpressure();
    test_random(13, 100);
    if (error_count == 0) begin
      $display("stereo_softclip_distortion_tb: clean");
    end else begin
      $display("stereo_softclip_distortion_tb: errors");
    end
    $finish;
  end

endmodule
